/* sv/clcd_pkg.sv */
// shared types and constants for the character lcd cursor engine
// depends on nothing; imported by every module of the block
`default_nettype none

package clcd_pkg;

    // terminal command codes on the cmd port
    localparam logic [4:0] CMD_UP     = 5'd0;
    localparam logic [4:0] CMD_DOWN   = 5'd1;
    localparam logic [4:0] CMD_RIGHT  = 5'd2;
    localparam logic [4:0] CMD_LEFT   = 5'd3;
    localparam logic [4:0] CMD_POS    = 5'd4;
    localparam logic [4:0] CMD_SAVE   = 5'd5;
    localparam logic [4:0] CMD_REST   = 5'd6;
    localparam logic [4:0] CMD_BS     = 5'd7;
    localparam logic [4:0] CMD_CR     = 5'd8;
    localparam logic [4:0] CMD_FF     = 5'd9;
    localparam logic [4:0] CMD_NL     = 5'd10;
    localparam logic [4:0] CMD_EL     = 5'd11;
    localparam logic [4:0] CMD_EEOL   = 5'd12;
    localparam logic [4:0] CMD_ESOL   = 5'd13;
    localparam logic [4:0] CMD_ES     = 5'd14;
    localparam logic [4:0] CMD_EEOS   = 5'd15;
    localparam logic [4:0] CMD_ESOS   = 5'd16;
    localparam logic [4:0] CMD_SCROLL = 5'd17;
    localparam logic [4:0] CMD_SHW    = 5'd18;

    // configuration register indexes
    localparam logic [2:0] REG_NUM_COLS   = 3'd0;
    localparam logic [2:0] REG_NUM_LINES  = 3'd1;
    localparam logic [2:0] REG_LINE0_BASE = 3'd2;
    localparam logic [2:0] REG_LINE1_BASE = 3'd3;
    localparam logic [2:0] REG_LINE2_BASE = 3'd4;
    localparam logic [2:0] REG_LINE3_BASE = 3'd5;

    localparam logic [7:0] LCD_SET_ADDR = 8'h80;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam int FQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef enum logic [4:0] {
        OP_UP, OP_DOWN, OP_RIGHT, OP_LEFT, OP_POS, OP_SAVE, OP_REST, OP_BS,
        OP_CR, OP_FF, OP_NL, OP_EL, OP_EEOL, OP_ESOL, OP_ES, OP_EEOS, OP_ESOS,
        OP_SCROLL, OP_SHW, OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] count;
        logic [7:0] row;
        logic [7:0] column;
        logic [6:0] shadow_addr;
        logic [7:0] shadow_data;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } lcd_byte_t;

endpackage

`default_nettype wire

/* sv/clcd_front.sv */
// front end: takes terminal commands, classifies them and queues them
// depends on clcd_pkg
`default_nettype none

module clcd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [4:0]         cmd,
    input  wire logic [7:0]         count,
    input  wire logic [7:0]         row,
    input  wire logic [7:0]         column,
    input  wire logic [6:0]         shadow_addr,
    input  wire logic [7:0]         shadow_data,
    output logic                    item_vld,
    output clcd_pkg::item_t         item,
    input  wire logic               item_take
);
    import clcd_pkg::*;

    item_t      entry_reg [FQ_DEPTH];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    op_t        op;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        case (cmd)
            CMD_UP:     op = (count == 8'd0) ? OP_NOP : OP_UP;
            CMD_DOWN:   op = (count == 8'd0) ? OP_NOP : OP_DOWN;
            CMD_RIGHT:  op = (count == 8'd0) ? OP_NOP : OP_RIGHT;
            CMD_LEFT:   op = (count == 8'd0) ? OP_NOP : OP_LEFT;
            CMD_POS:    op = OP_POS;
            CMD_SAVE:   op = OP_SAVE;
            CMD_REST:   op = OP_REST;
            CMD_BS:     op = OP_BS;
            CMD_CR:     op = OP_CR;
            CMD_FF:     op = OP_FF;
            CMD_NL:     op = OP_NL;
            CMD_EL:     op = OP_EL;
            CMD_EEOL:   op = OP_EEOL;
            CMD_ESOL:   op = OP_ESOL;
            CMD_ES:     op = OP_ES;
            CMD_EEOS:   op = OP_EEOS;
            CMD_ESOS:   op = OP_ESOS;
            CMD_SCROLL: op = OP_SCROLL;
            CMD_SHW:    op = OP_SHW;
            default:    op = OP_NOP;
        endcase
    end

    assign full     = (cnt_reg == 2'(FQ_DEPTH));
    assign item_vld = (cnt_reg != 2'd0);
    assign item     = entry_reg[rp_reg];
    assign do_push  = push && !full;
    assign do_pop   = item_take && item_vld;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= '{op: op, count: count, row: row, column: column,
                                   shadow_addr: shadow_addr, shadow_data: shadow_data};
        end
    end

endmodule

`default_nettype wire

/* sv/clcd_outq.sv */
// result queue holding lcd bytes until they are popped
// depends on clcd_pkg
`default_nettype none

module clcd_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire clcd_pkg::lcd_byte_t din,
    output logic                     full,
    input  wire logic                rd,
    output logic                     empty,
    output clcd_pkg::lcd_byte_t      dout
);
    import clcd_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);

    lcd_byte_t     q_reg [OQ_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign full   = (cnt_reg == (PW+1)'(OQ_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign dout   = q_reg[rp_reg];
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;

    always_comb
    begin
        cnt_next = cnt_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wp_reg] <= din;
        end
    end

endmodule

`default_nettype wire

/* sv/clcd_back.sv */
// back end: sequencer that carries out queued commands, owns cursor, config and shadow memory
// depends on clcd_pkg
`default_nettype none

module clcd_back #(
    parameter int SHADOW_DEPTH = 128,
    parameter int MAX_COLS     = 16,
    parameter int MAX_LINES    = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_vld,
    input  wire clcd_pkg::item_t   item,
    output logic                   item_take,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    output logic                   oq_wr,
    output clcd_pkg::lcd_byte_t    oq_din,
    input  wire logic              oq_full
);
    import clcd_pkg::*;

    localparam int AW = $clog2(SHADOW_DEPTH);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam logic [3:0] PH_PL = 4'd15;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SEQ   = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    function automatic logic [AW-1:0] sidx(input logic [6:0] a);
        if (32'(a) >= SHADOW_DEPTH)
        begin
            return AW'(32'(a) - SHADOW_DEPTH);
        end
        return AW'(a);
    endfunction

    // config
    logic [4:0] ncols_reg;
    logic [1:0] nlines_reg;
    logic [6:0] base_reg [4];

    // control
    state_t     st_reg, st_next;
    item_t      it_reg, it_next;
    logic [3:0] ph_reg, ph_next;
    logic [2:0] lp_reg, lp_next;
    logic [6:0] cursor_reg, cursor_next;
    logic [1:0] line_reg, line_next;
    logic [6:0] sv_addr_reg, sv_addr_next;
    logic [1:0] sv_line_reg, sv_line_next;
    logic [1:0] tline_reg, tline_next;
    logic [6:0] tcol_reg, tcol_next;
    logic       pend_vld_reg, pend_vld_next;
    logic       pend_kind_reg, pend_kind_next;
    logic [7:0] pend_val_reg, pend_val_next;

    // divider
    logic [8:0]    div_n_reg, div_n_next;
    logic [8:0]    div_q_reg, div_q_next;
    logic [CW-1:0] div_r_reg, div_r_next;
    logic [3:0]    div_i_reg, div_i_next;

    // byte runs
    logic          run_copy_reg, run_copy_next;
    logic          run_ph_reg, run_ph_next;
    logic [6:0]    run_dst_reg, run_dst_next;
    logic [6:0]    run_src_reg, run_src_next;
    logic [CW-1:0] run_n_reg, run_n_next;
    logic [3:0]    run_ret_reg, run_ret_next;

    // shadow memory
    logic [7:0]              mem [SHADOW_DEPTH];
    logic [SHADOW_DEPTH-1:0] valid_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_vld_reg;
    logic                    we;
    logic [AW-1:0]           widx;
    logic [7:0]              wdata;
    logic                    clr_all;

    logic          em_req;
    logic          em_kind;
    logic [7:0]    em_val;
    logic          can_emit;
    logic          fire;
    logic          flush_push;
    logic [CW-1:0] cols;
    logic [2:0]    lines;
    logic [1:0]    lm1;
    logic [6:0]    base_cur;
    logic [6:0]    curcol;
    logic [6:0]    pl_addr;
    logic [7:0]    ch;
    logic [7:0]    prod;
    logic [10:0]   pos;
    logic [8:0]    sum_dn;
    logic [9:0]    sum_rt;
    logic [CW:0]   rem_sh;
    logic [2:0]    lp_inc;
    logic [2:0]    lp_dec;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (ncols_reg == 5'd0)
        begin
            cols = CW'(1);
        end
        else if (32'(ncols_reg) > MAX_COLS)
        begin
            cols = CW'(MAX_COLS);
        end
        else
        begin
            cols = CW'(ncols_reg);
        end
        if (nlines_reg == 2'd0)
        begin
            lines = 3'd1;
        end
        else if (32'(nlines_reg) > MAX_LINES)
        begin
            lines = 3'(MAX_LINES);
        end
        else
        begin
            lines = {1'b0, nlines_reg};
        end
    end

    assign lm1      = 2'(lines - 3'd1);
    assign base_cur = base_reg[line_reg];
    assign curcol   = cursor_reg - base_cur;
    assign pl_addr  = base_reg[tline_reg] + tcol_reg;
    assign ch       = rd_vld_reg ? rd_data_reg : SPACE_CHAR;
    assign prod     = 8'(line_reg) * 8'(cols);
    assign sum_dn   = 9'(line_reg) + 9'(it_reg.count);
    assign sum_rt   = 10'(line_reg) + 10'(div_q_reg);
    assign rem_sh   = {div_r_reg, div_n_reg[8]};
    assign lp_inc   = lp_reg + 3'd1;
    assign lp_dec   = lp_reg - 3'd1;
    assign can_emit = !pend_vld_reg || !oq_full;
    assign fire     = em_req && can_emit;

    always_comb
    begin
        st_next        = st_reg;
        it_next        = it_reg;
        ph_next        = ph_reg;
        lp_next        = lp_reg;
        cursor_next    = cursor_reg;
        line_next      = line_reg;
        sv_addr_next   = sv_addr_reg;
        sv_line_next   = sv_line_reg;
        tline_next     = tline_reg;
        tcol_next      = tcol_reg;
        div_n_next     = div_n_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_i_next     = div_i_reg;
        run_copy_next  = run_copy_reg;
        run_ph_next    = run_ph_reg;
        run_dst_next   = run_dst_reg;
        run_src_next   = run_src_reg;
        run_n_next     = run_n_reg;
        run_ret_next   = run_ret_reg;
        item_take      = 1'b0;
        em_req         = 1'b0;
        em_kind        = KIND_CMD;
        em_val         = LCD_SET_ADDR | {1'b0, cursor_reg};
        we             = 1'b0;
        widx           = sidx(run_dst_reg);
        wdata          = SPACE_CHAR;
        clr_all        = 1'b0;
        pos            = 11'(prod) + 11'(curcol) - 11'(it_reg.count);

        case (st_reg)
            ST_IDLE:
            begin
                if (item_vld)
                begin
                    item_take = 1'b1;
                    it_next   = item;
                    ph_next   = 4'd0;
                    st_next   = ST_SEQ;
                end
            end

            ST_SEQ:
            begin
                if (ph_reg == PH_PL)
                begin
                    em_req = 1'b1;
                    em_val = LCD_SET_ADDR | {1'b0, pl_addr};
                    if (can_emit)
                    begin
                        line_next   = tline_reg;
                        cursor_next = pl_addr;
                        if (it_reg.op == OP_BS)
                        begin
                            ph_next = 4'd2;
                        end
                        else
                        begin
                            st_next = ST_FLUSH;
                        end
                    end
                end
                else
                begin
                    case (it_reg.op)
                        OP_UP:
                        begin
                            tline_next = ({6'd0, line_reg} >= it_reg.count)
                                ? 2'(8'(line_reg) - it_reg.count) : 2'd0;
                            tcol_next  = curcol;
                            ph_next    = PH_PL;
                        end
                        OP_DOWN:
                        begin
                            tline_next = (sum_dn > 9'(lm1)) ? lm1 : sum_dn[1:0];
                            tcol_next  = curcol;
                            ph_next    = PH_PL;
                        end
                        OP_RIGHT, OP_LEFT, OP_BS:
                        begin
                            if (it_reg.op == OP_RIGHT)
                            begin
                                div_n_next = 9'(curcol) + 9'(it_reg.count);
                            end
                            else
                            begin
                                if (it_reg.op == OP_BS)
                                begin
                                    pos = 11'(prod) + 11'(curcol) - 11'd1;
                                end
                                div_n_next = pos[10] ? 9'd0 : pos[8:0];
                            end
                            if (ph_reg == 4'd0)
                            begin
                                div_q_next = '0;
                                div_r_next = '0;
                                div_i_next = 4'd9;
                                st_next    = ST_DIV;
                            end
                            else if (ph_reg == 4'd2)
                            begin
                                em_req  = 1'b1;
                                em_kind = KIND_DATA;
                                em_val  = SPACE_CHAR;
                                if (can_emit)
                                begin
                                    ph_next = 4'd3;
                                end
                            end
                            else
                            begin
                                em_req = 1'b1;
                                if (can_emit)
                                begin
                                    st_next = ST_FLUSH;
                                end
                            end
                        end
                        OP_POS:
                        begin
                            tline_next = (it_reg.row > 8'(lm1)) ? lm1 : it_reg.row[1:0];
                            tcol_next  = (it_reg.column > 8'(cols - CW'(1)))
                                ? 7'(cols - CW'(1)) : it_reg.column[6:0];
                            ph_next    = PH_PL;
                        end
                        OP_SAVE:
                        begin
                            sv_addr_next = cursor_reg;
                            sv_line_next = line_reg;
                            st_next      = ST_FLUSH;
                        end
                        OP_REST:
                        begin
                            em_req = 1'b1;
                            em_val = LCD_SET_ADDR | {1'b0, sv_addr_reg};
                            if (can_emit)
                            begin
                                cursor_next = sv_addr_reg;
                                line_next   = sv_line_reg;
                                st_next     = ST_FLUSH;
                            end
                        end
                        OP_CR:
                        begin
                            tline_next = line_reg;
                            tcol_next  = 7'd0;
                            ph_next    = PH_PL;
                        end
                        OP_FF, OP_ES:
                        begin
                            em_req = 1'b1;
                            if (ph_reg == 4'd0)
                            begin
                                em_val = LCD_CLEAR;
                                if (can_emit)
                                begin
                                    clr_all = 1'b1;
                                    ph_next = 4'd1;
                                end
                            end
                            else if (can_emit)
                            begin
                                if (it_reg.op == OP_FF)
                                begin
                                    tline_next = 2'd0;
                                    tcol_next  = 7'd0;
                                    ph_next    = PH_PL;
                                end
                                else
                                begin
                                    st_next = ST_FLUSH;
                                end
                            end
                        end
                        OP_NL, OP_SCROLL:
                        begin
                            case (ph_reg)
                                4'd0:
                                begin
                                    lp_next = 3'd0;
                                    if (it_reg.op == OP_NL && line_reg < lm1)
                                    begin
                                        tline_next = line_reg + 2'd1;
                                        tcol_next  = 7'd0;
                                        ph_next    = PH_PL;
                                    end
                                    else
                                    begin
                                        ph_next = 4'd2;
                                    end
                                end
                                4'd2:
                                begin
                                    if (lp_inc < lines)
                                    begin
                                        em_req = 1'b1;
                                        em_val = LCD_SET_ADDR | {1'b0, base_reg[lp_reg[1:0]]};
                                        if (can_emit)
                                        begin
                                            ph_next = 4'd3;
                                        end
                                    end
                                    else
                                    begin
                                        ph_next = 4'd4;
                                    end
                                end
                                4'd3:
                                begin
                                    run_copy_next = 1'b1;
                                    run_ph_next   = 1'b0;
                                    run_dst_next  = base_reg[lp_reg[1:0]];
                                    run_src_next  = base_reg[lp_inc[1:0]];
                                    run_n_next    = cols;
                                    run_ret_next  = 4'd2;
                                    lp_next       = lp_inc;
                                    st_next       = ST_RUN;
                                end
                                4'd4:
                                begin
                                    em_req = 1'b1;
                                    em_val = LCD_SET_ADDR | {1'b0, base_reg[lm1]};
                                    if (can_emit)
                                    begin
                                        ph_next = 4'd5;
                                    end
                                end
                                4'd5:
                                begin
                                    run_copy_next = 1'b0;
                                    run_dst_next  = base_reg[lm1];
                                    run_n_next    = cols;
                                    run_ret_next  = 4'd6;
                                    st_next       = ST_RUN;
                                end
                                default:
                                begin
                                    em_req = 1'b1;
                                    if (can_emit)
                                    begin
                                        if (it_reg.op == OP_NL)
                                        begin
                                            tline_next = line_reg;
                                            tcol_next  = 7'd0;
                                            ph_next    = PH_PL;
                                        end
                                        else
                                        begin
                                            st_next = ST_FLUSH;
                                        end
                                    end
                                end
                            endcase
                        end
                        OP_EL, OP_EEOL, OP_ESOL, OP_EEOS, OP_ESOS:
                        begin
                            case (ph_reg)
                                4'd0:
                                begin
                                    em_req = 1'b1;
                                    if (it_reg.op != OP_EEOL && it_reg.op != OP_EEOS)
                                    begin
                                        em_val = LCD_SET_ADDR | {1'b0, base_cur};
                                    end
                                    if (can_emit)
                                    begin
                                        ph_next = 4'd1;
                                    end
                                end
                                4'd1:
                                begin
                                    run_copy_next = 1'b0;
                                    run_ret_next  = 4'd2;
                                    st_next       = ST_RUN;
                                    if (it_reg.op == OP_EEOL || it_reg.op == OP_EEOS)
                                    begin
                                        run_dst_next = cursor_reg;
                                        run_n_next   = (curcol < 7'(cols))
                                            ? CW'(7'(cols) - curcol) : CW'(0);
                                    end
                                    else
                                    begin
                                        run_dst_next = base_cur;
                                        if (it_reg.op == OP_EL)
                                        begin
                                            run_n_next = cols;
                                        end
                                        else
                                        begin
                                            run_n_next = (curcol < 7'(cols))
                                                ? CW'(curcol) : cols;
                                        end
                                    end
                                end
                                4'd2:
                                begin
                                    em_req = 1'b1;
                                    if (can_emit)
                                    begin
                                        if (it_reg.op == OP_EEOS)
                                        begin
                                            lp_next = 3'(line_reg) + 3'd1;
                                            ph_next = 4'd3;
                                        end
                                        else if (it_reg.op == OP_ESOS)
                                        begin
                                            lp_next = 3'(line_reg);
                                            ph_next = 4'd3;
                                        end
                                        else
                                        begin
                                            st_next = ST_FLUSH;
                                        end
                                    end
                                end
                                4'd3:
                                begin
                                    if (it_reg.op == OP_EEOS ? (lp_reg < lines)
                                                             : (lp_reg != 3'd0))
                                    begin
                                        em_req = 1'b1;
                                        em_val = LCD_SET_ADDR | {1'b0,
                                            (it_reg.op == OP_EEOS) ? base_reg[lp_reg[1:0]]
                                                                   : base_reg[lp_dec[1:0]]};
                                        if (can_emit)
                                        begin
                                            ph_next = 4'd4;
                                        end
                                    end
                                    else
                                    begin
                                        ph_next = 4'd5;
                                    end
                                end
                                4'd4:
                                begin
                                    run_copy_next = 1'b0;
                                    run_n_next    = cols;
                                    run_ret_next  = 4'd3;
                                    st_next       = ST_RUN;
                                    if (it_reg.op == OP_EEOS)
                                    begin
                                        run_dst_next = base_reg[lp_reg[1:0]];
                                        lp_next      = lp_inc;
                                    end
                                    else
                                    begin
                                        run_dst_next = base_reg[lp_dec[1:0]];
                                        lp_next      = lp_dec;
                                    end
                                end
                                default:
                                begin
                                    em_req = 1'b1;
                                    if (can_emit)
                                    begin
                                        st_next = ST_FLUSH;
                                    end
                                end
                            endcase
                        end
                        OP_SHW:
                        begin
                            we      = 1'b1;
                            widx    = sidx(it_reg.shadow_addr);
                            wdata   = it_reg.shadow_data;
                            st_next = ST_FLUSH;
                        end
                        default:
                        begin
                            st_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                if (div_i_reg == 4'd0)
                begin
                    tcol_next = 7'(div_r_reg);
                    if (it_reg.op == OP_RIGHT)
                    begin
                        tline_next = (sum_rt > 10'(lm1)) ? lm1 : sum_rt[1:0];
                    end
                    else
                    begin
                        tline_next = (div_q_reg > 9'(lm1)) ? lm1 : div_q_reg[1:0];
                    end
                    ph_next = PH_PL;
                    st_next = ST_SEQ;
                end
                else
                begin
                    div_n_next = {div_n_reg[7:0], 1'b0};
                    div_i_next = div_i_reg - 4'd1;
                    if (rem_sh >= {1'b0, cols})
                    begin
                        div_r_next = CW'(rem_sh - {1'b0, cols});
                        div_q_next = {div_q_reg[7:0], 1'b1};
                    end
                    else
                    begin
                        div_r_next = CW'(rem_sh);
                        div_q_next = {div_q_reg[7:0], 1'b0};
                    end
                end
            end

            ST_RUN:
            begin
                if (run_n_reg == '0)
                begin
                    ph_next = run_ret_reg;
                    st_next = ST_SEQ;
                end
                else if (run_copy_reg && !run_ph_reg)
                begin
                    run_ph_next = 1'b1;
                end
                else
                begin
                    em_req  = 1'b1;
                    em_kind = KIND_DATA;
                    em_val  = run_copy_reg ? ch : SPACE_CHAR;
                    if (can_emit)
                    begin
                        we           = 1'b1;
                        wdata        = em_val;
                        run_dst_next = run_dst_reg + 7'd1;
                        run_src_next = run_src_reg + 7'd1;
                        run_n_next   = run_n_reg - CW'(1);
                        run_ph_next  = 1'b0;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg || !oq_full)
                begin
                    st_next = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // one byte is held back so the final byte of a command can carry last
    assign flush_push = (st_reg == ST_FLUSH) && pend_vld_reg && !oq_full;
    assign oq_wr      = (fire && pend_vld_reg) || flush_push;
    assign oq_din     = '{kind: pend_kind_reg, value: pend_val_reg, last: flush_push};

    always_comb
    begin
        pend_vld_next  = pend_vld_reg;
        pend_kind_next = pend_kind_reg;
        pend_val_next  = pend_val_reg;
        if (fire)
        begin
            pend_vld_next  = 1'b1;
            pend_kind_next = em_kind;
            pend_val_next  = em_val;
        end
        else if (flush_push)
        begin
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncols_reg    <= 5'd16;
            nlines_reg   <= 2'd2;
            base_reg[0]  <= 7'd0;
            base_reg[1]  <= 7'd64;
            base_reg[2]  <= 7'd20;
            base_reg[3]  <= 7'd84;
            st_reg       <= ST_IDLE;
            ph_reg       <= 4'd0;
            lp_reg       <= 3'd0;
            cursor_reg   <= 7'd0;
            line_reg     <= 2'd0;
            sv_addr_reg  <= 7'd0;
            sv_line_reg  <= 2'd0;
            pend_vld_reg <= 1'b0;
            div_i_reg    <= 4'd0;
            run_n_reg    <= '0;
            run_ph_reg   <= 1'b0;
            run_copy_reg <= 1'b0;
            run_ret_reg  <= 4'd0;
            valid_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NUM_COLS:   ncols_reg   <= cfg_data[4:0];
                    REG_NUM_LINES:  nlines_reg  <= cfg_data[1:0];
                    REG_LINE0_BASE: base_reg[0] <= cfg_data;
                    REG_LINE1_BASE: base_reg[1] <= cfg_data;
                    REG_LINE2_BASE: base_reg[2] <= cfg_data;
                    REG_LINE3_BASE: base_reg[3] <= cfg_data;
                    default:        ;
                endcase
            end
            st_reg       <= st_next;
            ph_reg       <= ph_next;
            lp_reg       <= lp_next;
            cursor_reg   <= cursor_next;
            line_reg     <= line_next;
            sv_addr_reg  <= sv_addr_next;
            sv_line_reg  <= sv_line_next;
            pend_vld_reg <= pend_vld_next;
            div_i_reg    <= div_i_next;
            run_n_reg    <= run_n_next;
            run_ph_reg   <= run_ph_next;
            run_copy_reg <= run_copy_next;
            run_ret_reg  <= run_ret_next;
            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg        <= it_next;
        tline_reg     <= tline_next;
        tcol_reg      <= tcol_next;
        pend_kind_reg <= pend_kind_next;
        pend_val_reg  <= pend_val_next;
        div_n_reg     <= div_n_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        run_dst_reg   <= run_dst_next;
        run_src_reg   <= run_src_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[widx] <= wdata;
        end
        rd_data_reg <= mem[sidx(run_src_reg)];
        rd_vld_reg  <= valid_reg[sidx(run_src_reg)];
    end

endmodule

`default_nettype wire

/* sv/char_lcd_ansi_cursor_engine.sv */
// top level of the ansi cursor engine for a character lcd
// depends on clcd_pkg, clcd_front, clcd_back, clcd_outq
//
// Each accepted terminal command yields zero to a few dozen LCD bytes, the
// final one flagged by last. A two-entry command queue in front lets commands
// be pushed while the sequencer works. Cursor moves right, left and backspace
// run a serial divider that folds the column into lines, erase commands write
// their space bytes one after another, and each scrolled byte is a shadow
// memory read, then the write. Output stalls whenever the four-entry result
// queue is full, until bytes are popped. Form feed and erase screen clear the
// shadow memory at once through per-entry valid bits.
`default_nettype none

module char_lcd_ansi_cursor_engine #(
    parameter int SHADOW_DEPTH = 128,
    parameter int MAX_COLS     = 16,
    parameter int MAX_LINES    = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [4:0] cmd,
    input  wire logic [7:0] count,
    input  wire logic [7:0] row,
    input  wire logic [7:0] column,
    input  wire logic [6:0] shadow_addr,
    input  wire logic [7:0] shadow_data,
    output logic            empty,
    input  wire logic       pop,
    output logic            kind,
    output logic [7:0]      value,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [6:0] cfg_data
);
    import clcd_pkg::*;

    logic      item_vld;
    item_t     item;
    logic      item_take;
    logic      oq_wr;
    lcd_byte_t oq_din;
    logic      oq_full;
    lcd_byte_t oq_dout;

    clcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .count       (count),
        .row         (row),
        .column      (column),
        .shadow_addr (shadow_addr),
        .shadow_data (shadow_data),
        .item_vld    (item_vld),
        .item        (item),
        .item_take   (item_take)
    );

    clcd_back #(
        .SHADOW_DEPTH (SHADOW_DEPTH),
        .MAX_COLS     (MAX_COLS),
        .MAX_LINES    (MAX_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .oq_wr     (oq_wr),
        .oq_din    (oq_din),
        .oq_full   (oq_full)
    );

    clcd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (oq_wr),
        .din   (oq_din),
        .full  (oq_full),
        .rd    (pop),
        .empty (empty),
        .dout  (oq_dout)
    );

    assign kind  = oq_dout.kind;
    assign value = oq_dout.value;
    assign last  = oq_dout.last;

endmodule

`default_nettype wire
